// File: sv/rtpc_pkg.sv
// Package for the range to prefix cover block.
// Holds the item types and the shared adder operation codes; no dependencies.
package rtpc_pkg;

  // Fixed field widths of the items
  localparam int unsigned ValueW = 32;
  localparam int unsigned FreeW  = 6;

  // One interval to be covered
  typedef struct packed {
    logic [ValueW-1:0] low_value;
    logic [ValueW-1:0] high_value;
  } in_item_t;

  // One prefix of the cover, or the error marker
  typedef struct packed {
    logic [ValueW-1:0] block_base;
    logic [FreeW-1:0]  free_bits;
    logic              range_error;
    logic              last;
  } out_item_t;

  // Shared adder operations
  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

endpackage : rtpc_pkg

// File: sv/rtpc_alu.sv
// Shared add/subtract unit of the range to prefix cover block.
// Depends on rtpc_pkg for the operation codes.
module rtpc_alu #(
  parameter int unsigned Width = 33
) (
  input  rtpc_pkg::alu_op_e op_i,
  input  logic [Width-1:0]  a_i,
  input  logic [Width-1:0]  b_i,
  output logic [Width-1:0]  sum_o
);
  import rtpc_pkg::*;

  logic [Width-1:0] b_eff;
  logic             carry_in;

  // Subtract as a plus inverted b plus one
  always_comb begin
    unique case (op_i)
      ALU_ADD: begin
        b_eff    = b_i;
        carry_in = 1'b0;
      end
      ALU_SUB: begin
        b_eff    = ~b_i;
        carry_in = 1'b1;
      end
      default: begin
        b_eff    = b_i;
        carry_in = 1'b0;
      end
    endcase
  end

  assign sum_o = a_i + b_eff + Width'(carry_in);

endmodule : rtpc_alu

// File: sv/rtpc_out_reg.sv
// Output register of the range to prefix cover block.
// Holds one result item until taken; depends on rtpc_pkg for the item type.
module rtpc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rtpc_pkg::out_item_t data_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rtpc_pkg::out_item_t out_item_o
);
  import rtpc_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  // Slot can take a new item when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = data_q;

  // A push only ever lands in a free slot
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> free_o)
    else $error("push into occupied output slot");

endmodule : rtpc_out_reg

// File: sv/range_to_prefix_cover_top.sv
// Range to prefix cover: one interval in, the aligned prefixes covering it out.
// An item passes setup, a search for the top bit of the interval length one
// position at a time, placement of the pivot and the split of the lengths, then a
// walk down the bit positions, right block before left (one result per cycle at
// most), all through one shared adder; output stalls hold the walk. A reversed
// interval gives one error result. The next interval is taken once the last
// result sits in the output register. Depends on rtpc_pkg, rtpc_alu, rtpc_out_reg.
module range_to_prefix_cover_top #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rtpc_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rtpc_pkg::out_item_t out_item_o
);
  import rtpc_pkg::*;

  localparam int unsigned W    = VALUE_BITS + 1;
  localparam int unsigned IdxW = $clog2(VALUE_BITS + 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_DIFF  = 11'b000_0000_0010,
    ST_INC   = 11'b000_0000_0100,
    ST_FIND  = 11'b000_0000_1000,
    ST_PIVOT = 11'b000_0001_0000,
    ST_LPREV = 11'b000_0010_0000,
    ST_LLEN  = 11'b000_0100_0000,
    ST_RLEN  = 11'b000_1000_0000,
    ST_WALKR = 11'b001_0000_0000,
    ST_WALKL = 11'b010_0000_0000,
    ST_ERR   = 11'b100_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] bit_q, bit_d;

  // Working values, no reset
  logic [W-1:0] low_q, high_q, len_q, rpos_q, lpos_q, rlen_q, llen_q;
  logic [W-1:0] len_d, rpos_d, lpos_d, rlen_d, llen_d;

  logic [W-1:0] hi_mask, size;
  alu_op_e      alu_op;
  logic [W-1:0] alu_a, alu_b, alu_sum;

  logic      push, slot_free;
  out_item_t push_data;

  assign hi_mask = {W{1'b1}} << bit_q;
  assign size    = W'(1) << bit_q;

  assign in_ready_o = (state_q == ST_IDLE);

  // Shared adder
  rtpc_alu #(
    .Width(W)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sum_o(alu_sum)
  );

  // Sequencer and operand selection
  always_comb begin
    state_d   = state_q;
    bit_d     = bit_q;
    len_d     = len_q;
    rpos_d    = rpos_q;
    lpos_d    = lpos_q;
    rlen_d    = rlen_q;
    llen_d    = llen_q;
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    push      = 1'b0;
    push_data = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIFF;
        end
      end
      // high - low; sign bit flags a reversed interval
      ST_DIFF: begin
        alu_op = ALU_SUB;
        alu_a  = high_q;
        alu_b  = low_q;
        len_d  = alu_sum;
        state_d = alu_sum[W-1] ? ST_ERR : ST_INC;
      end
      ST_INC: begin
        alu_a   = len_q;
        alu_b   = W'(1);
        len_d   = alu_sum;
        bit_d   = IdxW'(VALUE_BITS);
        state_d = ST_FIND;
      end
      // Top set bit of the length, one position a cycle
      ST_FIND: begin
        if (len_q[bit_q]) begin
          state_d = ST_PIVOT;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      // Round low up to the alignment of the top length bit
      ST_PIVOT: begin
        alu_a   = low_q;
        alu_b   = ~hi_mask;
        rpos_d  = alu_sum & hi_mask;
        state_d = ST_LPREV;
      end
      ST_LPREV: begin
        alu_op  = ALU_SUB;
        alu_a   = rpos_q;
        alu_b   = W'(1);
        lpos_d  = alu_sum;
        state_d = ST_LLEN;
      end
      ST_LLEN: begin
        alu_op  = ALU_SUB;
        alu_a   = rpos_q;
        alu_b   = low_q;
        llen_d  = alu_sum;
        state_d = ST_RLEN;
      end
      ST_RLEN: begin
        alu_op  = ALU_SUB;
        alu_a   = len_q;
        alu_b   = llen_q;
        rlen_d  = alu_sum;
        state_d = ST_WALKR;
      end
      // Block right of the pivot at this position
      ST_WALKR: begin
        alu_a = rpos_q;
        alu_b = size;
        if (rlen_q[bit_q]) begin
          if (slot_free) begin
            push                  = 1'b1;
            push_data.block_base  = ValueW'((rpos_q & hi_mask) & {1'b0, {VALUE_BITS{1'b1}}});
            push_data.free_bits   = FreeW'(bit_q);
            push_data.last        = ((rlen_q & ~size) == '0) && (llen_q == '0);
            rpos_d                = alu_sum;
            rlen_d                = rlen_q & ~size;
            state_d               = push_data.last ? ST_IDLE : ST_WALKL;
          end
        end else begin
          state_d = ST_WALKL;
        end
      end
      // Block left of the pivot, then step down a position
      ST_WALKL: begin
        alu_op = ALU_SUB;
        alu_a  = lpos_q;
        alu_b  = size;
        if (llen_q[bit_q]) begin
          if (slot_free) begin
            push                  = 1'b1;
            push_data.block_base  = ValueW'((lpos_q & hi_mask) & {1'b0, {VALUE_BITS{1'b1}}});
            push_data.free_bits   = FreeW'(bit_q);
            push_data.last        = (rlen_q == '0) && ((llen_q & ~size) == '0);
            lpos_d                = alu_sum;
            llen_d                = llen_q & ~size;
            bit_d                 = bit_q - 1'b1;
            state_d               = push_data.last ? ST_IDLE : ST_WALKR;
          end
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = ST_WALKR;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          push                  = 1'b1;
          push_data.range_error = 1'b1;
          push_data.last        = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  // Working values; inputs masked to the value width on capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      low_q  <= {1'b0, in_item_i.low_value[VALUE_BITS-1:0]};
      high_q <= {1'b0, in_item_i.high_value[VALUE_BITS-1:0]};
    end
    len_q  <= len_d;
    rpos_q <= rpos_d;
    lpos_q <= lpos_d;
    rlen_q <= rlen_d;
    llen_q <= llen_d;
  end

  rtpc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (push_data),
    .free_o     (slot_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DIFF))
    else $error("accepted item did not start the sequence");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_data.range_error) |-> (push_data.last && push_data.free_bits == '0))
    else $error("error result malformed");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_data.free_bits <= FreeW'(VALUE_BITS)))
    else $error("prefix wider than the value width");

  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALKR || state_q == ST_WALKL) |-> (bit_q <= IdxW'(VALUE_BITS)))
    else $error("walk position out of range");

endmodule : range_to_prefix_cover_top

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for range_to_prefix_cover_top: directed intervals, then random ones.
// Depends on rtpc_pkg and the block; results checked against the table or a local predictor.
module testbench;
  import rtpc_pkg::*;

  localparam int unsigned ValueBits    = 32;
  localparam int unsigned MaxPrefixes  = 63;
  localparam int unsigned RandomItems  = 160;  // per idling phase
  localparam int unsigned DrainCycles  = 150;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned ShownErrors  = 10;

  // One row of the directed table
  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  out_item_t   pending_prefixes[$];
  row_t        directed_rows[$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned mismatches = 0;
  int unsigned intervals_sent = 0;
  int unsigned reversed_sent = 0;
  int unsigned exact_sent = 0;
  int unsigned prefixes_seen = 0;
  int unsigned cycles = 0;

  range_to_prefix_cover_top #(
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // 10 ns clock
  always #5 clk_i = ~clk_i;

  function automatic out_item_t make_prefix(logic [31:0] base, logic [5:0] free, logic err,
                                            logic fin);
    out_item_t p;
    p.block_base  = base;
    p.free_bits   = free;
    p.range_error = err;
    p.last        = fin;
    return p;
  endfunction

  // Work out the prefixes covering [lo, hi] and queue them up as expected results
  task automatic predict_cover(logic [31:0] lo, logic [31:0] hi);
    logic [63:0] span, align, pivot, right_len, left_len, right_pos, left_pos, size;
    int          top;
    out_item_t   blocks[$];
    if (lo > hi) begin
      pending_prefixes = {pending_prefixes, make_prefix('0, '0, 1'b1, 1'b1)};
      return;
    end
    span = {32'd0, hi} - {32'd0, lo} + 64'd1;
    top  = 0;
    for (int k = 0; k < 64; k++) if (span[k]) top = k + 1;
    align     = 64'd1 << (top - 1);
    pivot     = ({32'd0, lo} + align - 64'd1) & ~(align - 64'd1);
    right_len = {32'd0, hi} - pivot + 64'd1;
    left_len  = pivot - {32'd0, lo};
    right_pos = pivot;
    left_pos  = pivot - 64'd1;
    // walk bit positions, right block first, then left
    for (int b = top - 1; b >= 0; b--) begin
      size = 64'd1 << b;
      if (right_len[b] && blocks.size() < MaxPrefixes) begin
        blocks = {blocks, make_prefix(right_pos[31:0] & ~(size[31:0] - 32'd1), 6'(b), 1'b0,
                                      1'b0)};
        right_pos += size;
      end
      if (left_len[b] && blocks.size() < MaxPrefixes) begin
        blocks = {blocks, make_prefix(left_pos[31:0] & ~(size[31:0] - 32'd1), 6'(b), 1'b0,
                                      1'b0)};
        left_pos -= size;
      end
    end
    blocks[blocks.size() - 1].last = 1'b1;
    pending_prefixes = {pending_prefixes, blocks};
  endtask

  task automatic add_row(logic [31:0] lo, logic [31:0] hi, bit typed, logic [31:0] base,
                         logic [5:0] free, logic err);
    row_t r;
    r.stim.low_value  = lo;
    r.stim.high_value = hi;
    r.typed           = typed;
    r.want            = make_prefix(base, free, err, 1'b1);
    directed_rows     = {directed_rows, r};
  endtask

  // Random interval, mostly well-formed with a spread of lengths
  function automatic in_item_t random_interval();
    in_item_t    it;
    logic [63:0] lo, hi, mask;
    logic [31:0] a, b;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    a    = $urandom;
    b    = $urandom;
    mask = (64'd1 << $urandom_range(0, 32)) - 64'd1;
    lo   = {32'd0, a};
    case (kind)
      0: hi = {32'd0, b};                               // noise, often reversed
      1: hi = lo;                                       // single value
      2: begin                                          // reversed on purpose
        lo = (a > b) ? {32'd0, a} : {32'd0, b};
        hi = (a > b) ? {32'd0, b} : {32'd0, a};
      end
      3, 4, 5: hi = lo + ({32'd0, b} & mask);           // random length
      6, 7: begin                                       // wide sorted pair
        lo = (a < b) ? {32'd0, a} : {32'd0, b};
        hi = (a < b) ? {32'd0, b} : {32'd0, a};
      end
      8: begin                                          // aligned block, maybe nudged
        lo = ({32'd0, a} & ~mask) + 64'($urandom_range(0, 1));
        hi = ({32'd0, a} | mask) - 64'($urandom_range(0, 1));
      end
      default: begin                                    // near both ends
        lo = 64'($urandom_range(0, 15));
        hi = 64'hFFFF_FFFF - 64'($urandom_range(0, 15));
      end
    endcase
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    it.low_value  = lo[31:0];
    it.high_value = hi[31:0];
    return it;
  endfunction

  // Offer one item from a falling edge, hold it until accepted, return at the next falling edge
  task automatic send_interval(in_item_t it, bit typed, out_item_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) pending_prefixes = {pending_prefixes, want};
    else predict_cover(it.low_value, it.high_value);
    intervals_sent++;
    if (it.low_value > it.high_value) reversed_sent++;
    if (it.low_value == it.high_value) exact_sent++;
    @(negedge clk_i);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      prefixes_seen++;
      if (pending_prefixes.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("unexpected result: base %h free %0d err %b last %b", out_item_o.block_base,
                   out_item_o.free_bits, out_item_o.range_error, out_item_o.last);
      end else begin
        if (out_item_o.block_base !== pending_prefixes[0].block_base ||
            out_item_o.free_bits !== pending_prefixes[0].free_bits ||
            out_item_o.range_error !== pending_prefixes[0].range_error ||
            out_item_o.last !== pending_prefixes[0].last) begin
          mismatches++;
          if (mismatches <= ShownErrors)
            $display("mismatch (base/free/err/last): want %h/%0d/%b/%b got %h/%0d/%b/%b",
                     pending_prefixes[0].block_base, pending_prefixes[0].free_bits,
                     pending_prefixes[0].range_error, pending_prefixes[0].last,
                     out_item_o.block_base, out_item_o.free_bits, out_item_o.range_error,
                     out_item_o.last);
        end
        void'(pending_prefixes.pop_front());
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_prefixes.size());
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    out_item_t none;
    none = '0;
    // directed table: extremes, reversed intervals, exact values, full range
    add_row(32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 6'd0, 1'b0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 6'd0, 1'b0);
    add_row(32'h1234_5678, 32'h1234_5678, 1, 32'h1234_5678, 6'd0, 1'b0);
    add_row(32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000, 6'd32, 1'b0);
    add_row(32'h0000_0001, 32'h0000_0000, 1, 32'h0000_0000, 6'd0, 1'b1);
    add_row(32'hFFFF_FFFF, 32'h0000_0000, 1, 32'h0000_0000, 6'd0, 1'b1);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h0000_0000, 6'd0, 1'b1);
    add_row(32'hAAAA_AAAA, 32'h5555_5555, 1, 32'h0000_0000, 6'd0, 1'b1);
    add_row(32'h0000_0000, 32'h7FFF_FFFF, 1, 32'h0000_0000, 6'd31, 1'b0);
    add_row(32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h8000_0000, 6'd31, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0001, 0, '0, '0, 1'b0);
    add_row(32'h0000_0001, 32'h0000_0002, 0, '0, '0, 1'b0);
    add_row(32'h0000_0003, 32'h0000_0004, 0, '0, '0, 1'b0);
    add_row(32'h0000_0005, 32'h0000_001A, 0, '0, '0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 0, '0, '0, 1'b0);
    add_row(32'hFFFF_FFF0, 32'hFFFF_FFFF, 0, '0, '0, 1'b0);
    add_row(32'h5555_5555, 32'hAAAA_AAAA, 0, '0, '0, 1'b0);
    add_row(32'h0000_0001, 32'hFFFF_FFFE, 0, '0, '0, 1'b0);  // longest cover
    add_row(32'h0000_0000, 32'hFFFF_FFFE, 0, '0, '0, 1'b0);
    add_row(32'h0000_0001, 32'hFFFF_FFFF, 0, '0, '0, 1'b0);

    // reset
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // three idling patterns: slow receiver, slow sender, none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 21 : (phase == 1) ? 69 : 0;
      recv_idle = (phase == 0) ? 69 : (phase == 1) ? 21 : 0;
      if (phase == 0)
        foreach (directed_rows[r])
          send_interval(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
      for (int n = 0; n < RandomItems; n++) send_interval(random_interval(), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    // drain, then allow for stray results
    while (pending_prefixes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d intervals (%0d reversed, %0d single-value), checked %0d prefixes",
             intervals_sent, reversed_sent, exact_sent, prefixes_seen);
    $display("under slow-receiver, slow-sender and back-to-back handshakes; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
